@@ rtl/assert_macros.svh @@
// assertion macros used by the top level of the three-view scanner
// no dependencies; define SYNTH to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property that holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rstn, prop)
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/tvacs_pkg.sv @@
// shared constants, types and helpers of the three-view scanner
// no dependencies
`default_nettype none

package tvacs_pkg;

    localparam int MAX_STATES        = 4096;
    localparam int MAX_PATTERN_COUNT = 1024;
    localparam int ALPHABET          = 256;

    localparam int STATE_W   = $clog2(MAX_STATES);
    localparam int PAT_W     = $clog2(MAX_PATTERN_COUNT);
    localparam int SYM_W     = $clog2(ALPHABET);
    localparam int TRANS_AW  = STATE_W + SYM_W;
    localparam int TRANS_DEPTH = MAX_STATES * ALPHABET;

    // walkers
    localparam int VIEWS       = 3;
    localparam int VIEW_FULL   = 0;
    localparam int VIEW_LETTER = 1;
    localparam int VIEW_OTHER  = 2;

    // result queue
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_TRANS = 2'd0,
        MODE_MATCH = 2'd1,
        MODE_SCAN  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        RC_CLEAN  = 2'd0,
        RC_LETTER = 2'd1,
        RC_OTHER  = 2'd2,
        RC_FULL   = 2'd3
    } result_code_t;

    typedef struct packed {
        logic               flag;
        logic [PAT_W-1:0]   pattern;
    } match_entry_t;

    typedef struct packed {
        logic                en;
        logic [TRANS_AW-1:0] addr;
        logic [STATE_W-1:0]  data;
    } trans_wr_t;

    typedef struct packed {
        logic                en;
        logic [TRANS_AW-1:0] addr;
    } trans_rd_t;

    typedef struct packed {
        logic               en;
        logic [STATE_W-1:0] addr;
        match_entry_t       entry;
    } match_wr_t;

    typedef struct packed {
        logic               en;
        logic [STATE_W-1:0] addr;
    } match_rd_t;

    typedef struct packed {
        result_code_t     code;
        logic [PAT_W-1:0] pattern;
    } result_t;

    function automatic logic is_letter(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] low;
        low = c | SYM_W'(8'h20);
        return (low >= SYM_W'(8'h61)) && (low <= SYM_W'(8'h7a));
    endfunction

endpackage

`default_nettype wire

@@ rtl/tvacs_trans_mem.sv @@
// dfa transition memory: one write port, two registered read ports
// depends on tvacs_pkg
`default_nettype none

module tvacs_trans_mem (
    input  wire logic                          aclk,
    input  wire tvacs_pkg::trans_wr_t          wr,
    input  wire tvacs_pkg::trans_rd_t          rd_a,
    input  wire tvacs_pkg::trans_rd_t          rd_b,
    output logic [tvacs_pkg::STATE_W-1:0]      rd_a_data,
    output logic [tvacs_pkg::STATE_W-1:0]      rd_b_data
);
    import tvacs_pkg::*;

    logic [STATE_W-1:0] mem [TRANS_DEPTH];

    // read-first: a read in the same cycle as a write sees the old entry
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_a.en) begin
            rd_a_data <= mem[rd_a.addr];
        end
        if (rd_b.en) begin
            rd_b_data <= mem[rd_b.addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tvacs_match_mem.sv @@
// per-state match entry memory: one write port, two registered read ports
// depends on tvacs_pkg
`default_nettype none

module tvacs_match_mem (
    input  wire logic                      aclk,
    input  wire tvacs_pkg::match_wr_t      wr,
    input  wire tvacs_pkg::match_rd_t      rd_a,
    input  wire tvacs_pkg::match_rd_t      rd_b,
    output tvacs_pkg::match_entry_t        rd_a_data,
    output tvacs_pkg::match_entry_t        rd_b_data
);
    import tvacs_pkg::*;

    match_entry_t mem [MAX_STATES];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd_a.en) begin
            rd_a_data <= mem[rd_a.addr];
        end
        if (rd_b.en) begin
            rd_b_data <= mem[rd_b.addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tvacs_out_fifo.sv @@
// small result queue in flops, drives the result channel
// depends on tvacs_pkg
`default_nettype none

module tvacs_out_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire tvacs_pkg::result_t    push_data,
    input  wire logic                  pop,
    output logic                       out_valid,
    output tvacs_pkg::result_t         out_data
);
    import tvacs_pkg::*;

    result_t               slot_reg [OUT_DEPTH];
    logic [OUT_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [OUT_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0]  count_reg, count_next;
    logic                  do_pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OUT_CNT_W'(push) - OUT_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/three_view_aho_corasick_scan.sv @@
// top level of the three-view aho-corasick scanner
// depends on tvacs_pkg, tvacs_trans_mem, tvacs_match_mem, tvacs_out_fifo, assert_macros.svh
`default_nettype none

// Scans a byte stream against a loaded Aho-Corasick DFA with three walkers at
// once: the full view walks on every byte, the letter view only on ASCII
// letters, the other view only on non-letters. Load the table first with
// mode 0 transactions (state, byte -> next state) and mode 1 transactions
// (state -> accepting flag, longest pattern index); unwritten entries must
// never be reached by a scan. Mode 2 transactions carry the text, one byte
// each; the one marked last_byte yields a single result transaction (code 3
// full view hit, else 1 letter view, else 2 other view, else 0 clean) and
// returns all walkers to state 0. A byte-less scan with last_byte reports
// the walkers as they stand. The block takes one transaction per cycle
// without gaps while s_ready is high: each byte reads the transition memory
// at the state forwarded from the previous byte's read data register, so
// the walkers' feedback loop is one memory read. A report passes the
// transition read, match read, latch and result queue in turn before it
// leaves the block. Up to 8 reports may be outstanding; past that s_ready
// drops until m_ready drains the result queue. There is no clearing pass.
module three_view_aho_corasick_scan (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_mode,
    input  wire logic [tvacs_pkg::STATE_W-1:0] s_table_state,
    input  wire logic [tvacs_pkg::SYM_W-1:0]   s_symbol,
    input  wire logic [tvacs_pkg::STATE_W-1:0] s_next_state_value,
    input  wire logic                          s_accepting,
    input  wire logic [tvacs_pkg::PAT_W-1:0]   s_longest_index,
    input  wire logic                          s_last_byte,
    input  wire logic                          s_byte_present,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_result_code,
    output logic [tvacs_pkg::PAT_W-1:0]        m_match_pattern
);
    import tvacs_pkg::*;
    `include "assert_macros.svh"

    // input register (first stage)
    logic                  s1_valid_reg;
    logic [1:0]            s1_mode_reg;
    logic [STATE_W-1:0]    s1_state_reg;
    logic [SYM_W-1:0]      s1_sym_reg;
    logic [STATE_W-1:0]    s1_tgt_reg;
    logic                  s1_acc_reg;
    logic [PAT_W-1:0]      s1_lidx_reg;
    logic                  s1_last_reg;
    logic                  s1_present_reg;

    logic                  s_accept;
    logic                  s1_scan;
    logic                  s1_walk;
    logic                  s1_letter;
    logic [VIEWS-1:0]      s1_walk_vec;

    // second stage: transition read data is valid here
    logic [VIEWS-1:0]      s2_walk_reg;
    logic                  s2_clear_reg;

    // third stage: match read data is valid here
    logic [VIEWS-1:0]      s3_walk_reg;
    logic                  s3_clear_reg;

    // walker state after the byte in the second stage
    logic [STATE_W-1:0]    walker_state_reg [VIEWS];
    logic [STATE_W-1:0]    cur_state [VIEWS];

    // per-walker first-match latch
    logic [VIEWS-1:0]      found_reg, found_next;
    logic [PAT_W-1:0]      pat_reg [VIEWS];
    logic [PAT_W-1:0]      pat_next [VIEWS];
    logic [VIEWS-1:0]      hit;

    // outstanding reports
    logic [OUT_CNT_W-1:0]  pend_reg, pend_next;
    logic                  pend_inc, pend_dec;

    trans_wr_t             trans_wr;
    trans_rd_t             trans_rd_a, trans_rd_b;
    logic [STATE_W-1:0]    trans_a_data, trans_b_data;
    match_wr_t             match_wr;
    match_rd_t             match_rd_a, match_rd_b;
    match_entry_t          match_a_data, match_b_data;
    result_t               res, out_res;

    // ---------------- input side ----------------
    assign s_ready  = (pend_reg < OUT_CNT_W'(OUT_DEPTH));
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
        end
    end

    // payload only loads on a transaction
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_mode_reg    <= s_mode;
            s1_state_reg   <= s_table_state;
            s1_sym_reg     <= s_symbol;
            s1_tgt_reg     <= s_next_state_value;
            s1_acc_reg     <= s_accepting;
            s1_lidx_reg    <= s_longest_index;
            s1_last_reg    <= s_last_byte;
            s1_present_reg <= s_byte_present;
        end
    end

    // ---------------- first stage: table writes and transition reads ----------------
    assign s1_scan   = s1_valid_reg && (s1_mode_reg == MODE_SCAN);
    assign s1_walk   = s1_scan && s1_present_reg;
    assign s1_letter = is_letter(s1_sym_reg);

    always_comb begin
        s1_walk_vec              = '0;
        s1_walk_vec[VIEW_FULL]   = s1_walk;
        s1_walk_vec[VIEW_LETTER] = s1_walk && s1_letter;
        s1_walk_vec[VIEW_OTHER]  = s1_walk && !s1_letter;
    end

    // current walker state: forwarded from the byte in the second stage,
    // zero right after a report
    always_comb begin
        for (int w = 0; w < VIEWS; w++) begin
            if (s2_clear_reg) begin
                cur_state[w] = '0;
            end else if (s2_walk_reg[w]) begin
                cur_state[w] = (w == VIEW_FULL) ? trans_a_data : trans_b_data;
            end else begin
                cur_state[w] = walker_state_reg[w];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < VIEWS; w++) begin
                walker_state_reg[w] <= '0;
            end
        end else begin
            for (int w = 0; w < VIEWS; w++) begin
                walker_state_reg[w] <= cur_state[w];
            end
        end
    end

    always_comb begin
        trans_wr.en   = s1_valid_reg && (s1_mode_reg == MODE_TRANS);
        trans_wr.addr = {s1_state_reg, s1_sym_reg};
        trans_wr.data = s1_tgt_reg;

        // port a serves the full view, port b whichever partial view the byte feeds
        trans_rd_a.en   = s1_walk;
        trans_rd_a.addr = {cur_state[VIEW_FULL], s1_sym_reg};
        trans_rd_b.en   = s1_walk;
        trans_rd_b.addr = {s1_letter ? cur_state[VIEW_LETTER] : cur_state[VIEW_OTHER],
                           s1_sym_reg};

        match_wr.en            = s1_valid_reg && (s1_mode_reg == MODE_MATCH);
        match_wr.addr          = s1_state_reg;
        match_wr.entry.flag    = s1_acc_reg;
        match_wr.entry.pattern = s1_lidx_reg;
    end

    tvacs_trans_mem u_trans_mem (
        .aclk      (aclk),
        .wr        (trans_wr),
        .rd_a      (trans_rd_a),
        .rd_b      (trans_rd_b),
        .rd_a_data (trans_a_data),
        .rd_b_data (trans_b_data)
    );

    // ---------------- second stage: match entry reads ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_walk_reg  <= '0;
            s2_clear_reg <= 1'b0;
            s3_walk_reg  <= '0;
            s3_clear_reg <= 1'b0;
        end else begin
            s2_walk_reg  <= s1_walk_vec;
            s2_clear_reg <= s1_scan && s1_last_reg;
            s3_walk_reg  <= s2_walk_reg;
            s3_clear_reg <= s2_clear_reg;
        end
    end

    always_comb begin
        match_rd_a.en   = s2_walk_reg[VIEW_FULL];
        match_rd_a.addr = trans_a_data;
        match_rd_b.en   = s2_walk_reg[VIEW_LETTER] || s2_walk_reg[VIEW_OTHER];
        match_rd_b.addr = trans_b_data;
    end

    tvacs_match_mem u_match_mem (
        .aclk      (aclk),
        .wr        (match_wr),
        .rd_a      (match_rd_a),
        .rd_b      (match_rd_b),
        .rd_a_data (match_a_data),
        .rd_b_data (match_b_data)
    );

    // ---------------- third stage: first-match latch and report ----------------
    // walks after a walker's first match change nothing it reports,
    // so the latch only keeps the earliest hit
    always_comb begin
        hit[VIEW_FULL]   = s3_walk_reg[VIEW_FULL]   && match_a_data.flag;
        hit[VIEW_LETTER] = s3_walk_reg[VIEW_LETTER] && match_b_data.flag;
        hit[VIEW_OTHER]  = s3_walk_reg[VIEW_OTHER]  && match_b_data.flag;
        for (int w = 0; w < VIEWS; w++) begin
            found_next[w] = found_reg[w] || hit[w];
            if (!found_reg[w] && hit[w]) begin
                pat_next[w] = (w == VIEW_FULL) ? match_a_data.pattern
                                               : match_b_data.pattern;
            end else begin
                pat_next[w] = pat_reg[w];
            end
        end
    end

    // priority: full view, then letters, then non-letters
    always_comb begin
        if (found_next[VIEW_FULL]) begin
            res.code    = RC_FULL;
            res.pattern = pat_next[VIEW_FULL];
        end else if (found_next[VIEW_LETTER]) begin
            res.code    = RC_LETTER;
            res.pattern = pat_next[VIEW_LETTER];
        end else if (found_next[VIEW_OTHER]) begin
            res.code    = RC_OTHER;
            res.pattern = pat_next[VIEW_OTHER];
        end else begin
            res.code    = RC_CLEAN;
            res.pattern = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || s3_clear_reg) begin
            found_reg <= '0;
            for (int w = 0; w < VIEWS; w++) begin
                pat_reg[w] <= '0;
            end
        end else begin
            found_reg <= found_next;
            for (int w = 0; w < VIEWS; w++) begin
                pat_reg[w] <= pat_next[w];
            end
        end
    end

    tvacs_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s3_clear_reg),
        .push_data (res),
        .pop       (m_ready),
        .out_valid (m_valid),
        .out_data  (out_res)
    );

    assign m_result_code   = out_res.code;
    assign m_match_pattern = out_res.pattern;

    // ---------------- outstanding report count ----------------
    // counts from acceptance so the queue can never overflow
    always_comb begin
        pend_inc  = s_accept && (s_mode == MODE_SCAN) && s_last_byte;
        pend_dec  = m_valid && m_ready;
        pend_next = pend_reg + OUT_CNT_W'(pend_inc) - OUT_CNT_W'(pend_dec);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // ---------------- checks ----------------
    `ASSERT_ALWAYS(a_pend_bound, aclk, aresetn, pend_reg <= OUT_CNT_W'(OUT_DEPTH))
    `ASSERT_IMPL(a_no_result_unowed, aclk, aresetn, pend_reg == '0, !m_valid)
    `ASSERT_NEXT(a_latch_cleared, aclk, aresetn, s3_clear_reg, found_reg == '0)
    `ASSERT_IMPL(a_one_partial_view, aclk, aresetn, s2_walk_reg[VIEW_LETTER],
                 !s2_walk_reg[VIEW_OTHER] && s2_walk_reg[VIEW_FULL])

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// testbench for three_view_aho_corasick_scan: loads a small dfa over a fixed byte set, runs
// directed and random transactions, checks each report against the predictor or a typed row
// depends on tvacs_pkg and the three_view_aho_corasick_scan rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tvacs_pkg::*;

    // mode code that the block must ignore
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // run control
    localparam int RANDOM_ITEMS   = 270;
    localparam int PHASE_B_START  = 65;
    localparam int PHASE_C_START  = 130;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_REPORTED   = 10;

    // live states: every transition out of these over SCAN_SYMS is written before any scan,
    // and every transition written among them points back into the set, so a walker never
    // reads an entry that was never loaded
    localparam int NUM_LIVE = 7;
    localparam logic [STATE_W-1:0] ST_ROOT  = 12'h000;
    localparam logic [STATE_W-1:0] ST_ONE   = 12'h001;
    localparam logic [STATE_W-1:0] ST_TWO   = 12'h002;
    localparam logic [STATE_W-1:0] ST_THREE = 12'h003;
    localparam logic [STATE_W-1:0] ST_LO    = 12'h555;
    localparam logic [STATE_W-1:0] ST_MID   = 12'hAAA;
    localparam logic [STATE_W-1:0] ST_TOP   = 12'hFFF;
    localparam logic [NUM_LIVE*STATE_W-1:0] LIVE_STATES =
        {ST_TOP, ST_MID, ST_LO, ST_THREE, ST_TWO, ST_ONE, ST_ROOT};

    // scanned byte set: all four letter corners, the non-letters right next to them,
    // both byte extremes, a dot and a high byte whose folded value is no letter
    localparam int NUM_SYMS = 12;
    localparam logic [SYM_W-1:0] SYM_NUL    = 8'h00;
    localparam logic [SYM_W-1:0] SYM_ALL    = 8'hFF;
    localparam logic [SYM_W-1:0] SYM_UP_A   = 8'h41;
    localparam logic [SYM_W-1:0] SYM_UP_Z   = 8'h5A;
    localparam logic [SYM_W-1:0] SYM_LO_A   = 8'h61;
    localparam logic [SYM_W-1:0] SYM_LO_Z   = 8'h7A;
    localparam logic [SYM_W-1:0] SYM_AT     = 8'h40;
    localparam logic [SYM_W-1:0] SYM_LBRK   = 8'h5B;
    localparam logic [SYM_W-1:0] SYM_GRAVE  = 8'h60;
    localparam logic [SYM_W-1:0] SYM_LBRACE = 8'h7B;
    localparam logic [SYM_W-1:0] SYM_DOT    = 8'h2E;
    localparam logic [SYM_W-1:0] SYM_HIGH   = 8'hC1;
    localparam logic [NUM_SYMS*SYM_W-1:0] SCAN_SYMS =
        {SYM_HIGH, SYM_DOT, SYM_LBRACE, SYM_GRAVE, SYM_LBRK, SYM_AT,
         SYM_LO_Z, SYM_LO_A, SYM_UP_Z, SYM_UP_A, SYM_ALL, SYM_NUL};

    // one input transaction
    typedef struct {
        logic [1:0]         mode;
        logic [STATE_W-1:0] state;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] target;
        logic               acc;
        logic [PAT_W-1:0]   pat;
        logic               last;
        logic               present;
    } dfa_txn_t;

    // one row of the directed table; typed rows carry the report written out by hand
    typedef struct {
        dfa_txn_t txn;
        bit       typed;
        result_t  want;
    } plan_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_mode;
    logic [STATE_W-1:0] s_table_state;
    logic [SYM_W-1:0]   s_symbol;
    logic [STATE_W-1:0] s_next_state_value;
    logic               s_accepting;
    logic [PAT_W-1:0]   s_longest_index;
    logic               s_last_byte;
    logic               s_byte_present;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_result_code;
    logic [PAT_W-1:0]   m_match_pattern;

    three_view_aho_corasick_scan u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_table_state     (s_table_state),
        .s_symbol          (s_symbol),
        .s_next_state_value(s_next_state_value),
        .s_accepting       (s_accepting),
        .s_longest_index   (s_longest_index),
        .s_last_byte       (s_last_byte),
        .s_byte_present    (s_byte_present),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_code     (m_result_code),
        .m_match_pattern   (m_match_pattern)
    );

    // shadow copy of the loaded dfa and of the three walkers
    logic [STATE_W-1:0] trans_shadow [logic [TRANS_AW-1:0]];
    logic               accept_shadow  [MAX_STATES];
    logic [PAT_W-1:0]   pattern_shadow [MAX_STATES];
    logic [STATE_W-1:0] view_state [VIEWS];
    logic               view_hit   [VIEWS];
    logic [PAT_W-1:0]   view_pat   [VIEWS];

    // reports still owed by the block, oldest first
    result_t   pending_reports [$];
    plan_row_t plan [$];

    int mismatches;
    int idle_cycles;
    int s_idle_pct;
    int r_idle_pct;
    bit hold_req;
    result_t want;

    // clock: 8 ns period
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------------------------

    // one walker takes one byte unless it has already latched a match
    function automatic void walk_view(input int v, input logic [SYM_W-1:0] c);
        logic [STATE_W-1:0] nxt;
        if (view_hit[v])
            return;
        nxt = trans_shadow[{view_state[v], c}];
        view_state[v] = nxt;
        if (accept_shadow[nxt]) begin
            view_hit[v] = 1'b1;
            view_pat[v] = pattern_shadow[nxt];
        end
    endfunction

    function automatic void clear_views();
        for (int v = 0; v < VIEWS; v++) begin
            view_state[v] = '0;
            view_hit[v]   = 1'b0;
            view_pat[v]   = '0;
        end
    endfunction

    // applies one accepted transaction to the shadow and says whether it yields a report
    function automatic void predict_txn(input dfa_txn_t t, output bit fires,
                                        output result_t rpt);
        logic [SYM_W-1:0] folded;
        logic             letter;
        fires  = 1'b0;
        rpt    = '0;
        folded = t.sym | 8'h20;
        letter = (folded >= 8'h61) && (folded <= 8'h7A);
        // 12-bit fields can never address past the 4096-entry tables, so no write is dropped
        if (t.mode == MODE_TRANS) begin
            trans_shadow[{t.state, t.sym}] = t.target;
        end else if (t.mode == MODE_MATCH) begin
            accept_shadow[t.state]  = t.acc;
            pattern_shadow[t.state] = t.pat;
        end else if (t.mode == MODE_SCAN) begin
            if (t.present) begin
                walk_view(VIEW_FULL, t.sym);
                if (letter)
                    walk_view(VIEW_LETTER, t.sym);
                else
                    walk_view(VIEW_OTHER, t.sym);
            end
            if (t.last) begin
                fires = 1'b1;
                // full view wins over letter view, letter over other; clean reports pattern 0
                if (view_hit[VIEW_FULL]) begin
                    rpt.code    = RC_FULL;
                    rpt.pattern = view_pat[VIEW_FULL];
                end else if (view_hit[VIEW_LETTER]) begin
                    rpt.code    = RC_LETTER;
                    rpt.pattern = view_pat[VIEW_LETTER];
                end else if (view_hit[VIEW_OTHER]) begin
                    rpt.code    = RC_OTHER;
                    rpt.pattern = view_pat[VIEW_OTHER];
                end
                clear_views();
            end
        end
    endfunction

    // ---------------------------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------------------------

    function automatic logic [SYM_W-1:0] pick_sym();
        int i;
        i = $urandom_range(0, NUM_SYMS - 1);
        return SCAN_SYMS[i*SYM_W +: SYM_W];
    endfunction

    function automatic logic [STATE_W-1:0] pick_live();
        int i;
        i = $urandom_range(0, NUM_LIVE - 1);
        return LIVE_STATES[i*STATE_W +: STATE_W];
    endfunction

    function automatic bit is_live(input logic [STATE_W-1:0] st);
        for (int i = 0; i < NUM_LIVE; i++)
            if (LIVE_STATES[i*STATE_W +: STATE_W] == st)
                return 1'b1;
        return 1'b0;
    endfunction

    // a transaction the block acts on: a table write, or a scan with a byte or an end mark
    function automatic bit is_effective(input dfa_txn_t t);
        return (t.mode == MODE_TRANS) || (t.mode == MODE_MATCH) ||
               ((t.mode == MODE_SCAN) && (t.present || t.last));
    endfunction

    // random transaction: mostly text over the byte set, with table rewrites that keep
    // the walkers inside the live states, plus writes to dead states and ignored modes
    function automatic dfa_txn_t rand_txn();
        dfa_txn_t t;
        int       r;
        // every field starts fully random so ignored fields toggle too
        t.mode    = 2'($urandom);
        t.state   = STATE_W'($urandom);
        t.sym     = SYM_W'($urandom);
        t.target  = STATE_W'($urandom);
        t.acc     = 1'($urandom);
        t.pat     = PAT_W'($urandom);
        t.last    = 1'($urandom);
        t.present = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < 62) begin
            t.mode    = MODE_SCAN;
            t.sym     = pick_sym();
            t.present = ($urandom_range(0, 19) != 0);
            t.last    = ($urandom_range(0, 4) == 0);
        end else if (r < 80) begin
            t.mode   = MODE_TRANS;
            t.state  = pick_live();
            t.sym    = pick_sym();
            t.target = pick_live();
        end else if (r < 90) begin
            t.mode  = MODE_MATCH;
            t.state = pick_live();
            t.acc   = ($urandom_range(0, 3) == 0);
        end else if (r < 96) begin
            // write to a state no walker can reach
            t.mode = $urandom_range(0, 1) ? MODE_TRANS : MODE_MATCH;
            while (is_live(t.state))
                t.state = STATE_W'($urandom);
        end else begin
            t.mode = MODE_UNUSED;
        end
        return t;
    endfunction

    function automatic void plan_row(input logic [1:0] mode, input logic [STATE_W-1:0] st,
                                     input logic [SYM_W-1:0] sym,
                                     input logic [STATE_W-1:0] tgt, input logic acc,
                                     input logic [PAT_W-1:0] pat, input logic last,
                                     input logic present, input bit typed,
                                     input result_code_t code,
                                     input logic [PAT_W-1:0] want_pat);
        plan_row_t r;
        r.txn.mode         = mode;
        r.txn.state        = st;
        r.txn.sym          = sym;
        r.txn.target       = tgt;
        r.txn.acc          = acc;
        r.txn.pat          = pat;
        r.txn.last         = last;
        r.txn.present      = present;
        r.typed            = typed;
        r.want.code        = code;
        r.want.pattern     = want_pat;
        plan.push_back(r);
    endfunction

    // drives one transaction from a falling edge, holds it until accepted, then predicts;
    // a typed row's expectation replaces the predicted one
    task automatic send_txn(input dfa_txn_t t, input bit typed, input result_t typed_want);
        bit      fires;
        result_t rpt;
        @(negedge aclk);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_mode             <= t.mode;
        s_table_state      <= t.state;
        s_symbol           <= t.sym;
        s_next_state_value <= t.target;
        s_accepting        <= t.acc;
        s_longest_index    <= t.pat;
        s_last_byte        <= t.last;
        s_byte_present     <= t.present;
        do
            @(posedge aclk);
        while (!s_ready);
        predict_txn(t, fires, rpt);
        if (fires)
            pending_reports.push_back(typed ? typed_want : rpt);
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------------------------

    // receiver: random back-pressure per phase, and one long hold-off on request that lets
    // the result queue fill and the block stall its input
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= r_idle_pct);
            end
        end
    end

    // every accepted report is compared with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                note_mismatch($sformatf("report code %0d pattern %0d with none expected",
                                        m_result_code, m_match_pattern));
            end else begin
                want = pending_reports.pop_front();
                if (m_result_code !== want.code || m_match_pattern !== want.pattern)
                    note_mismatch($sformatf("expected code %0d pattern %0d, got %0d %0d",
                                            want.code, want.pattern,
                                            m_result_code, m_match_pattern));
            end
        end
    end

    // watchdog: too long without any transaction on either side ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------------------------
    initial begin
        dfa_txn_t t;
        int       applied;
        bit       hold_done;

        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_mode             = MODE_SCAN;
        s_table_state      = '0;
        s_symbol           = '0;
        s_next_state_value = '0;
        s_accepting        = 1'b0;
        s_longest_index    = '0;
        s_last_byte        = 1'b0;
        s_byte_present     = 1'b0;
        mismatches         = 0;
        idle_cycles        = 0;
        hold_req           = 1'b0;
        hold_done          = 1'b0;
        applied            = 0;
        // first phase: idle percentages of 36 for the sender and 80 for the receiver
        s_idle_pct         = 36;
        r_idle_pct         = 80;
        clear_views();
        for (int i = 0; i < MAX_STATES; i++) begin
            accept_shadow[i]  = 1'b0;
            pattern_shadow[i] = '0;
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // base load: every live state goes to root on every scanned byte, none accepting
        for (int s = 0; s < NUM_LIVE; s++) begin
            for (int c = 0; c < NUM_SYMS; c++) begin
                t = '{MODE_TRANS, LIVE_STATES[s*STATE_W +: STATE_W],
                      SCAN_SYMS[c*SYM_W +: SYM_W], ST_ROOT, 1'b0, '0, 1'b0, 1'b0};
                send_txn(t, 1'b0, '0);
            end
            t = '{MODE_MATCH, LIVE_STATES[s*STATE_W +: STATE_W], SYM_NUL, ST_ROOT, 1'b0, '0,
                  1'b0, 1'b0};
            send_txn(t, 1'b0, '0);
        end

        // directed table
        //        mode         state     symbol      target    acc   pattern  last  byte
        //        typed  code       pattern
        // empty text right after the base load reports clean
        plan_row(MODE_SCAN,   ST_ROOT,  SYM_NUL,    ST_ROOT,  1'b0, 10'd0,   1'b1, 1'b0,
                 1'b1, RC_CLEAN,  10'd0);
        // byte-less scan that is not last does nothing
        plan_row(MODE_SCAN,   ST_ROOT,  SYM_NUL,    ST_ROOT,  1'b0, 10'd0,   1'b0, 1'b0,
                 1'b0, RC_CLEAN,  10'd0);
        // unused mode with every field at its top is ignored
        plan_row(MODE_UNUSED, ST_TOP,   SYM_ALL,    ST_TOP,   1'b1, 10'h3FF, 1'b1, 1'b1,
                 1'b0, RC_CLEAN,  10'd0);
        // "a" reaches the top state, which ends the highest pattern index
        plan_row(MODE_TRANS,  ST_ROOT,  SYM_LO_A,   ST_TOP,   1'b0, 10'd0,   1'b0, 1'b0,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_MATCH,  ST_TOP,   SYM_NUL,    ST_ROOT,  1'b1, 10'h3FF, 1'b0, 1'b0,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_SCAN,   ST_ROOT,  SYM_LO_A,   ST_ROOT,  1'b0, 10'd0,   1'b1, 1'b1,
                 1'b1, RC_FULL,   10'h3FF);
        // walkers are back at root after a report
        plan_row(MODE_SCAN,   ST_ROOT,  SYM_NUL,    ST_ROOT,  1'b0, 10'd0,   1'b1, 1'b0,
                 1'b1, RC_CLEAN,  10'd0);
        // ". a": full view detours through state three, letter view still sees "a"
        plan_row(MODE_TRANS,  ST_ROOT,  SYM_DOT,    ST_THREE, 1'b0, 10'd0,   1'b0, 1'b0,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_TRANS,  ST_THREE, SYM_LO_A,   ST_ROOT,  1'b0, 10'd0,   1'b0, 1'b0,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_SCAN,   ST_ROOT,  SYM_DOT,    ST_ROOT,  1'b0, 10'd0,   1'b0, 1'b1,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_SCAN,   ST_ROOT,  SYM_LO_A,   ST_ROOT,  1'b0, 10'd0,   1'b1, 1'b1,
                 1'b0, RC_CLEAN,  10'd0);
        // "A 0xff": only the non-letter view sees 0xff from root
        plan_row(MODE_TRANS,  ST_ROOT,  SYM_UP_A,   ST_LO,    1'b0, 10'd0,   1'b0, 1'b0,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_TRANS,  ST_LO,    SYM_ALL,    ST_LO,    1'b0, 10'd0,   1'b0, 1'b0,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_TRANS,  ST_ROOT,  SYM_ALL,    ST_MID,   1'b0, 10'd0,   1'b0, 1'b0,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_MATCH,  ST_MID,   SYM_NUL,    ST_ROOT,  1'b1, 10'd0,   1'b0, 1'b0,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_SCAN,   ST_ROOT,  SYM_UP_A,   ST_ROOT,  1'b0, 10'd0,   1'b0, 1'b1,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_SCAN,   ST_ROOT,  SYM_ALL,    ST_ROOT,  1'b0, 10'd0,   1'b1, 1'b1,
                 1'b0, RC_CLEAN,  10'd0);
        // table written in the middle of a text applies to the bytes after it
        plan_row(MODE_SCAN,   ST_ROOT,  SYM_UP_A,   ST_ROOT,  1'b0, 10'd0,   1'b0, 1'b1,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_TRANS,  ST_LO,    SYM_LO_Z,   ST_ONE,   1'b0, 10'd0,   1'b0, 1'b0,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_MATCH,  ST_ONE,   SYM_NUL,    ST_ROOT,  1'b1, 10'h2AA, 1'b0, 1'b0,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_SCAN,   ST_ROOT,  SYM_LO_Z,   ST_ROOT,  1'b0, 10'd0,   1'b1, 1'b1,
                 1'b0, RC_CLEAN,  10'd0);
        // writes to states no walker reaches, with extreme fields
        plan_row(MODE_TRANS,  12'hFFE,  SYM_ALL,    ST_TOP,   1'b1, 10'h3FF, 1'b1, 1'b1,
                 1'b0, RC_CLEAN,  10'd0);
        plan_row(MODE_MATCH,  12'h800,  SYM_ALL,    ST_TOP,   1'b1, 10'h3FF, 1'b1, 1'b1,
                 1'b0, RC_CLEAN,  10'd0);
        // a nul byte stays at root, which is not accepting
        plan_row(MODE_SCAN,   ST_ROOT,  SYM_NUL,    ST_ROOT,  1'b0, 10'd0,   1'b1, 1'b1,
                 1'b1, RC_CLEAN,  10'd0);

        foreach (plan[i])
            send_txn(plan[i].txn, plan[i].typed, plan[i].want);

        // random part in three idling phases; only transactions the block acts on count
        while (applied < RANDOM_ITEMS) begin
            if (applied < PHASE_B_START) begin
                s_idle_pct = 36;
                r_idle_pct = 80;
            end else if (applied < PHASE_C_START) begin
                s_idle_pct = 80;
                r_idle_pct = 36;
            end else begin
                s_idle_pct = 0;
                r_idle_pct = 0;
                // long receiver hold-off while the sender keeps streaming
                if (!hold_done) begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
            end
            t = rand_txn();
            send_txn(t, 1'b0, '0);
            if (is_effective(t))
                applied++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then keep watching for anything unexpected
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
